// ===== hdl/carv_pkg.sv =====
// Package: shared constants, state codes, line tables and saturation for the reverb.
`timescale 1ns / 1ps
`default_nettype none
package carv_pkg;

	localparam int SmpBits   = 16;
	localparam int PreDepth  = 1024;
	localparam int CombLines = 8;
	localparam int ApLines   = 4;
	localparam int CombTotal = 11024;
	localparam int ApTotal   = 1563;

	localparam logic signed [16:0] LowAlpha  = 17'sd6554;
	localparam logic signed [16:0] HighAlpha = 17'sd3277;
	localparam logic signed [23:0] SqWeight  = 24'sd4294967;

	// register indexes of the write port
	localparam logic [2:0] RegCombFb   = 3'd0;
	localparam logic [2:0] RegCombDamp = 3'd1;
	localparam logic [2:0] RegWetMix   = 3'd2;
	localparam logic [2:0] RegBypass   = 3'd3;
	localparam logic [2:0] RegEarly    = 3'd4;
	localparam logic [2:0] RegLate     = 3'd5;
	localparam logic [2:0] RegLevels   = 3'd6;
	localparam logic [2:0] RegPreLen   = 3'd7;

	localparam logic [13:0] CB_BASE [CombLines] = '{
		14'd0, 14'd1116, 14'd2304, 14'd3581, 14'd4937, 14'd6359, 14'd7850, 14'd9407};
	localparam logic [10:0] CB_LEN [CombLines] = '{
		11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617};
	localparam logic [10:0] AP_BASE [ApLines] = '{11'd0, 11'd556, 11'd997, 11'd1338};
	localparam logic [9:0]  AP_LEN  [ApLines] = '{10'd556, 10'd441, 10'd341, 10'd225};

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_PRE, ST_PRE_WAIT, ST_AP_RD, ST_AP_WR,
		ST_CB_RD, ST_CB_MUL, ST_CB_UPD, ST_CB_WR, ST_WET_MUL, ST_WET_SUM,
		ST_LOW_MUL, ST_LOW_UPD, ST_HIGH_UPD, ST_MIX_MUL, ST_MIX_SAT,
		ST_SQ_MUL, ST_AVG_MUL, ST_AVG_ADD, ST_OUT
	} state_t;

	function automatic logic signed [15:0] sat_smp(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7fff;
		end else if (v < -24'sd32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/comb_allpass_reverb.sv =====
// Top level: comb/allpass reverb with pre-delay, tone filters, mix and level meters.
`timescale 1ns / 1ps
// Steps per item: pre-delay, each allpass line, each comb line, sum, tone and mix, the
// levels when on, and loading the output; bypass skips to the mix. One item at a time
// over the 13 delay lines: the next item is taken the cycle after the result is loaded,
// so a new item is not taken before the last one is through.
// Reset: asynchronous, clears control and filter state, then a clearing pass
// zeroes all delay memories; no item is taken during it.
`default_nettype none
module comb_allpass_reverb (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] in_sample
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [15:0] out_sample, [31:16] peak_mag,
	                                         // [62:32] mean_square, [63] zero
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);
	import carv_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [15:0] comb_fb_q, comb_damp_q, wet_mix_q, early_gain_q, late_gain_q;
	logic        bypass_q, levels_q;
	logic [10:0] pre_len_q;

	// sequencer and per-line state
	logic [13:0] clr_q;
	logic [2:0]  line_q;
	logic [9:0]  pre_pos_q;
	logic [10:0] cb_pos_q [CombLines];
	logic [9:0]  ap_pos_q [ApLines];
	logic signed [15:0] damp_q [CombLines];
	logic signed [15:0] low_q, high_q;
	logic [15:0] peak_q;
	logic [30:0] avg_q;

	// working registers of one item
	logic signed [15:0] x_q, s_q, wet_q, y_q;
	logic signed [18:0] early_q, late_q;
	logic signed [33:0] prod1_q, lp_prod_q, hp_prod_q;
	logic signed [32:0] prod2_q;
	logic signed [35:0] pe_q, pl_q;
	logic signed [34:0] mx_q;
	logic [30:0] sq_q;
	logic signed [56:0] avg_prod_q;
	logic [63:0] out_data_q;
	logic        out_valid_q;

	// memories
	logic signed [15:0] cb_mem [CombTotal];
	logic signed [15:0] ap_mem [ApTotal];
	logic signed [15:0] pre_mem [PreDepth];
	logic signed [15:0] cb_rdata_q, ap_rdata_q, pre_rdata_q;
	logic        cb_we, ap_we, pre_we;
	logic [13:0] cb_waddr, cb_raddr;
	logic [10:0] ap_waddr, ap_raddr;
	logic [9:0]  pre_waddr, pre_raddr;
	logic signed [15:0] cb_wdata, ap_wdata, pre_wdata;

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// ---- address and arithmetic helpers ----
	logic [10:0] pd_len;
	logic [9:0]  pd_idx, pd_next;
	assign pd_len  = (pre_len_q > 11'(PreDepth)) ? 11'(PreDepth) : pre_len_q;
	assign pd_idx  = ({1'b0, pre_pos_q} >= pd_len) ? 10'd0 : pre_pos_q;
	assign pd_next = ((11'(pd_idx) + 11'd1) >= pd_len) ? 10'd0 : pd_idx + 10'd1;

	logic [1:0]  ap_idx;
	logic [10:0] ap_addr;
	logic [9:0]  ap_pnext;
	assign ap_idx   = line_q[1:0];
	assign ap_addr  = AP_BASE[ap_idx] + 11'(ap_pos_q[ap_idx]);
	assign ap_pnext = ((ap_pos_q[ap_idx] + 10'd1) >= AP_LEN[ap_idx]) ? 10'd0
	                  : ap_pos_q[ap_idx] + 10'd1;

	logic [13:0] cb_addr;
	logic [10:0] cb_pnext;
	assign cb_addr  = CB_BASE[line_q] + 14'(cb_pos_q[line_q]);
	assign cb_pnext = ((cb_pos_q[line_q] + 11'd1) >= CB_LEN[line_q]) ? 11'd0
	                  : cb_pos_q[line_q] + 11'd1;

	// allpass feedback of one half: round half up of d/2
	logic signed [15:0] ap_half, ap_wval;
	assign ap_half = 16'((17'(ap_rdata_q) + 17'sd1) >>> 1);
	assign ap_wval = sat_smp(24'(s_q) + 24'(ap_half));

	logic signed [15:0] cb_st, cb_st_new, cb_wval;
	logic signed [17:0] cb_rnd1;
	logic signed [16:0] cb_rnd2;
	assign cb_st     = damp_q[line_q];
	assign cb_rnd1   = 18'((prod1_q + 34'sd32768) >>> 16);
	assign cb_st_new = sat_smp(24'(cb_st) + 24'(cb_rnd1));
	assign cb_rnd2   = 17'((prod2_q + 33'sd32768) >>> 16);
	assign cb_wval   = sat_smp(24'(s_q) + 24'(cb_rnd2));

	logic signed [19:0] pe_rnd;
	logic signed [16:0] pl_rnd;
	logic signed [15:0] wet_new;
	assign pe_rnd  = 20'((pe_q + 36'sd32768) >>> 16);
	assign pl_rnd  = 17'((pl_q + 36'sd262144) >>> 19);   // late gain carries the /8
	assign wet_new = sat_smp(24'(pe_rnd) + 24'(pl_rnd));

	logic signed [15:0] low_new, high_new;
	logic signed [16:0] hp_in;
	assign low_new  = sat_smp(24'(low_q) + 24'(18'((lp_prod_q + 34'sd32768) >>> 16)));
	assign hp_in    = 17'(low_new) - 17'(high_q);
	assign high_new = sat_smp(24'(high_q) + 24'(18'((hp_prod_q + 34'sd32768) >>> 16)));

	logic signed [17:0] dry_share;
	logic signed [16:0] wet_share;
	logic signed [15:0] y_new;
	assign dry_share = $signed({1'b0, 17'(17'd65536 - {1'b0, wet_mix_q})});
	assign wet_share = $signed({1'b0, wet_mix_q});
	assign y_new     = sat_smp(24'(19'((mx_q + 35'sd32768) >>> 16)));

	logic [16:0] y_abs;
	logic [15:0] mag;
	logic signed [32:0] sq_diff;
	logic signed [31:0] avg_sum;
	assign y_abs   = y_q[15] ? 17'(-(17'(y_q))) : 17'(y_q);
	assign mag     = y_abs[15:0];
	assign sq_diff = $signed({2'b0, sq_q}) - $signed({2'b0, avg_q});
	assign avg_sum = $signed({1'b0, avg_q}) + 32'(25'((avg_prod_q + 57'sd2147483648) >>> 32));

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (clr_q == 14'(CombTotal - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) begin
					if (bypass_q)          state_d = ST_MIX_MUL;
					else if (pd_len != '0) state_d = ST_PRE;
					else                   state_d = ST_AP_RD;
				end
			end
			ST_PRE:      state_d = ST_PRE_WAIT;
			ST_PRE_WAIT: state_d = ST_AP_RD;
			ST_AP_RD:    state_d = ST_AP_WR;
			ST_AP_WR:    state_d = (line_q == 3'(ApLines - 1)) ? ST_CB_RD : ST_AP_RD;
			ST_CB_RD:    state_d = ST_CB_MUL;
			ST_CB_MUL:   state_d = ST_CB_UPD;
			ST_CB_UPD:   state_d = ST_CB_WR;
			ST_CB_WR:    state_d = (line_q == 3'(CombLines - 1)) ? ST_WET_MUL : ST_CB_RD;
			ST_WET_MUL:  state_d = ST_WET_SUM;
			ST_WET_SUM:  state_d = ST_LOW_MUL;
			ST_LOW_MUL:  state_d = ST_LOW_UPD;
			ST_LOW_UPD:  state_d = ST_HIGH_UPD;
			ST_HIGH_UPD: state_d = ST_MIX_MUL;
			ST_MIX_MUL:  state_d = ST_MIX_SAT;
			ST_MIX_SAT:  state_d = levels_q ? ST_SQ_MUL : ST_OUT;
			ST_SQ_MUL:   state_d = ST_AVG_MUL;
			ST_AVG_MUL:  state_d = ST_AVG_ADD;
			ST_AVG_ADD:  state_d = ST_OUT;
			ST_OUT:      if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---- memory control and handshake ----
	always_comb begin
		s_axis_tready = 1'b0;
		cb_we = 1'b0;  cb_waddr = cb_addr;  cb_raddr = cb_addr;  cb_wdata = cb_wval;
		ap_we = 1'b0;  ap_waddr = ap_addr;  ap_raddr = ap_addr;  ap_wdata = ap_wval;
		pre_we = 1'b0; pre_waddr = pd_idx;  pre_raddr = pd_idx;  pre_wdata = x_q;
		unique case (state_q)
			ST_CLEAR: begin
				cb_we     = 1'b1;
				cb_waddr  = clr_q;
				cb_wdata  = '0;
				ap_we     = (clr_q < 14'(ApTotal));
				ap_waddr  = clr_q[10:0];
				ap_wdata  = '0;
				pre_we    = (clr_q < 14'(PreDepth));
				pre_waddr = clr_q[9:0];
				pre_wdata = '0;
			end
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_PRE:   pre_we = 1'b1;     // read-first: old sample comes back
			ST_AP_WR: ap_we = 1'b1;
			ST_CB_WR: cb_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cb_we) cb_mem[cb_waddr] <= cb_wdata;
		cb_rdata_q <= cb_mem[cb_raddr];
	end

	always_ff @(posedge clk) begin
		if (ap_we) ap_mem[ap_waddr] <= ap_wdata;
		ap_rdata_q <= ap_mem[ap_raddr];
	end

	always_ff @(posedge clk) begin
		if (pre_we) pre_mem[pre_waddr] <= pre_wdata;
		pre_rdata_q <= pre_mem[pre_raddr];
	end

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_fb_q    <= 16'd55050;
			comb_damp_q  <= 16'd13107;
			wet_mix_q    <= 16'd19661;
			bypass_q     <= 1'b0;
			early_gain_q <= 16'd19661;
			late_gain_q  <= 16'd45875;
			levels_q     <= 1'b0;
			pre_len_q    <= 11'd882;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegCombFb:   comb_fb_q    <= cfg_data;
				RegCombDamp: comb_damp_q  <= cfg_data;
				RegWetMix:   wet_mix_q    <= cfg_data;
				RegBypass:   bypass_q     <= cfg_data[0];
				RegEarly:    early_gain_q <= cfg_data;
				RegLate:     late_gain_q  <= cfg_data;
				RegLevels:   levels_q     <= cfg_data[0];
				RegPreLen:   pre_len_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			line_q      <= '0;
			pre_pos_q   <= '0;
			cb_pos_q    <= '{default: '0};
			ap_pos_q    <= '{default: '0};
			damp_q      <= '{default: '0};
			low_q       <= '0;
			high_q      <= '0;
			peak_q      <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 14'd1;
			// output register: load a new result once the old one is gone
			if (state_q == ST_OUT && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:     line_q <= '0;
				ST_PRE:      pre_pos_q <= pd_next;
				ST_AP_WR: begin
					ap_pos_q[ap_idx] <= ap_pnext;
					line_q <= (line_q == 3'(ApLines - 1)) ? 3'd0 : line_q + 3'd1;
				end
				ST_CB_UPD:   damp_q[line_q] <= cb_st_new;
				ST_CB_WR: begin
					cb_pos_q[line_q] <= cb_pnext;
					line_q <= line_q + 3'd1;
				end
				ST_LOW_UPD:  low_q <= low_new;
				ST_HIGH_UPD: high_q <= high_new;
				ST_SQ_MUL:   if (mag > peak_q) peak_q <= mag;
				ST_AVG_ADD:  avg_q <= avg_sum[30:0];
				default: ;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= $signed(s_axis_tdata);
				s_q     <= $signed(s_axis_tdata);
				wet_q   <= $signed(s_axis_tdata);   // bypass path
				early_q <= '0;
				late_q  <= '0;
			end
			ST_PRE_WAIT: s_q <= pre_rdata_q;
			ST_AP_WR:    early_q <= early_q + 19'(ap_rdata_q) - 19'(s_q);
			ST_CB_MUL:   prod1_q <= (17'(cb_rdata_q) - 17'(cb_st)) * $signed({1'b0, comb_damp_q});
			ST_CB_UPD: begin
				late_q  <= late_q + 19'(cb_st_new);
				prod2_q <= cb_st_new * $signed({1'b0, comb_fb_q});
			end
			ST_WET_MUL: begin
				pe_q <= early_q * $signed({1'b0, early_gain_q});
				pl_q <= late_q * $signed({1'b0, late_gain_q});
			end
			ST_WET_SUM:  wet_q <= wet_new;
			ST_LOW_MUL:  lp_prod_q <= (17'(wet_q) - 17'(low_q)) * LowAlpha;
			ST_LOW_UPD: begin
				hp_prod_q <= hp_in * HighAlpha;
				wet_q     <= sat_smp(24'(hp_in));
			end
			ST_MIX_MUL:  mx_q <= x_q * dry_share + wet_q * wet_share;
			ST_MIX_SAT:  y_q <= y_new;
			ST_SQ_MUL:   sq_q <= 31'(32'(mag) * 32'(mag));
			ST_AVG_MUL:  avg_prod_q <= sq_diff * SqWeight;
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready)
					out_data_q <= {1'b0, avg_q, peak_q, y_q};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// an accepted item always starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("item accepted but sequencer idle");

	// peak hold never falls
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		##1 peak_q >= $past(peak_q))
		else $error("peak hold decreased");

	// comb read pointer stays inside its line
	a_cb_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CB_RD |-> cb_pos_q[line_q] < CB_LEN[line_q])
		else $error("comb position out of line");

	// no item is taken before the clearing pass has finished
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_acc)
		else $error("item accepted during clearing pass");
`endif

endmodule
`default_nettype wire
